// File: hdl/pewe_pkg.sv
// Package for the polarizer efficiency core: widths, fixed-point constants,
// status codes and the records handed from cell to cell. No dependencies.
package pewe_pkg;

  localparam int IN_FRAC   = 16;  // fraction bits of the input fields
  localparam int FRAC_BITS = 16;  // fraction bits of the results
  localparam int QW        = 32;  // quotient bits, one per divider cell
  localparam int DW        = 84;  // divisor and remainder width
  localparam int RTW       = 32;  // root bits, one per root cell
  localparam int RDW       = 2 * RTW;
  localparam int SRW       = RTW + 2;
  localparam int EFF_SH    = IN_FRAC - 1 + FRAC_BITS;
  localparam int ERR_SH    = IN_FRAC + FRAC_BITS;
  localparam int NW        = 64 + ERR_SH;  // widest shifted dividend
  localparam int LANES     = 4;            // efficiency and three error terms

  localparam logic [17:0]        CELL_ONE = 18'd1 << IN_FRAC;
  localparam logic signed [35:0] EFF_MAX  = 36'sd8388607;
  localparam logic signed [35:0] EFF_MIN  = -36'sd8388608;
  localparam logic signed [35:0] EFF_HALF = 36'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SUM_ZERO = 2'd1,
    ST_HALF     = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic [QW-1:0] num_lo;
  } div_t;

  typedef struct packed {
    logic [SRW-1:0] rem;
    logic [RTW-1:0] root;
    logic [RDW-1:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic [23:0] eff;
    logic [31:0] err;
    status_e     st;
  } res_t;

endpackage

// File: hdl/pewe_div_cell.sv
// One restoring division cell: develops one quotient bit per cycle while en_i is high.
// Depends on pewe_pkg.
module pewe_div_cell import pewe_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t d_i,
  output div_t d_o
);

  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          take;
  div_t          d_d;
  div_t          d_q;

  always_comb begin
    r2          = {d_i.rem, d_i.num_lo[QW-1]};
    diff        = r2 - {1'b0, d_i.den};
    take        = r2 >= {1'b0, d_i.den};
    d_d.rem     = take ? diff[DW-1:0] : r2[DW-1:0];
    d_d.den     = d_i.den;
    d_d.quo     = {d_i.quo[QW-2:0], take};
    d_d.num_lo  = {d_i.num_lo[QW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// File: hdl/pewe_sqrt_cell.sv
// One digit-by-digit square root cell: develops one root bit per cycle while en_i is high.
// Depends on pewe_pkg.
module pewe_sqrt_cell import pewe_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t d_i,
  output sqrt_t d_o
);

  logic [SRW+1:0] r2;
  logic [SRW+1:0] trial;
  logic           take;
  sqrt_t          d_d;
  sqrt_t          d_q;

  always_comb begin
    r2        = {d_i.rem, d_i.rad[RDW-1:RDW-2]};
    trial     = {2'b00, d_i.root, 2'b01};
    take      = r2 >= trial;
    d_d.rem   = take ? SRW'(r2 - trial) : SRW'(r2);
    d_d.root  = {d_i.root[RTW-2:0], take};
    d_d.rad   = {d_i.rad[RDW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// File: hdl/pewe_out_fifo.sv
// Two-entry result buffer between the pipeline and the output channel.
// Depends on pewe_pkg.
module pewe_out_fifo import pewe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hdl/polarizer_efficiency_with_error_core.sv
// Polarizer efficiency and propagated error, one wavelength bin per item.
// Depends on pewe_pkg, pewe_div_cell, pewe_sqrt_cell, pewe_out_fifo.
//
//  channel  | dir | payload (tdata, low bits first)
//  s_axis   | in  | off_off_intensity, off_on_intensity, off_off_error,
//           |     | off_on_error, cell_efficiency, cell_efficiency_error
//  m_axis   | out | polarizer_efficiency, efficiency_error, status
//
// One item per cycle sustained unless the pipeline stalls. From the accepting edge
// to m_axis_tvalid an item passes 4 product/setup stages after the input stage, a
// row of 32 divider cells (four lanes side by side), 2 stages for rounding and squares,
// a row of 32 root cells, one result stage and the write into the output buffer.
// Reset clears the valid chain and the two-entry output buffer.
// The pipeline stalls only when its last stage holds an item and the output
// buffer is full; s_axis_tready does not depend on m_axis_tready.
module polarizer_efficiency_with_error_core import pewe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // A[31:0], B[63:32], EA[95:64], EB[127:96], C[144:128], EC[161:145]
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // efficiency[23:0], error[55:24], status[57:56]
  output logic [63:0]  m_axis_tdata
);

  localparam int NSTG = 8 + QW + RTW;
  localparam int P1   = 5 + QW;
  localparam int SQ0  = 6 + QW;

  logic            en;
  logic            fifo_full;
  logic [NSTG-1:0] vld_q;

  assign en            = !(vld_q[NSTG-1] && fifo_full);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // stage 1: sums, differences, flags
  logic [31:0] in_a, in_b;
  logic [17:0] c2;
  logic [32:0] s1_s_d;
  logic        neg_n, neg_d;
  logic [31:0] s1_mn_d;
  logic [17:0] s1_md_d;
  status_e     s1_st_d;

  logic [31:0] s1_a_q, s1_b_q, s1_ea_q, s1_eb_q, s1_mn_q;
  logic [16:0] s1_ec_q;
  logic [32:0] s1_s_q;
  logic [17:0] s1_md_q;
  logic        s1_neg_q;
  status_e     s1_st_q;

  always_comb begin
    in_a    = s_axis_tdata[31:0];
    in_b    = s_axis_tdata[63:32];
    c2      = {s_axis_tdata[144:128], 1'b0};
    s1_s_d  = {1'b0, in_a} + {1'b0, in_b};
    neg_n   = in_b > in_a;
    s1_mn_d = neg_n ? in_b - in_a : in_a - in_b;
    neg_d   = c2 < CELL_ONE;
    s1_md_d = neg_d ? CELL_ONE - c2 : c2 - CELL_ONE;
    if (s1_s_d == '0) begin
      s1_st_d = ST_SUM_ZERO;
    end else if (s1_md_d == '0) begin
      s1_st_d = ST_HALF;
    end else begin
      s1_st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q   <= in_a;
      s1_b_q   <= in_b;
      s1_ea_q  <= s_axis_tdata[95:64];
      s1_eb_q  <= s_axis_tdata[127:96];
      s1_ec_q  <= s_axis_tdata[161:145];
      s1_s_q   <= s1_s_d;
      s1_mn_q  <= s1_mn_d;
      s1_md_q  <= s1_md_d;
      s1_neg_q <= neg_n ^ neg_d;
      s1_st_q  <= s1_st_d;
    end
  end

  // stage 2: first products
  logic [50:0] s2_sd_q;
  logic [63:0] s2_bea_q, s2_aeb_q;
  logic [48:0] s2_nec_q;
  logic [65:0] s2_ss_q;
  logic [35:0] s2_dd_q;
  logic [32:0] s2_s_q;
  logic [31:0] s2_mn_q;
  logic [17:0] s2_md_q;
  logic        s2_neg_q;
  status_e     s2_st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sd_q  <= 51'(s1_s_q) * 51'(s1_md_q);
      s2_bea_q <= 64'(s1_b_q) * 64'(s1_ea_q);
      s2_aeb_q <= 64'(s1_a_q) * 64'(s1_eb_q);
      s2_nec_q <= 49'(s1_mn_q) * 49'(s1_ec_q);
      s2_ss_q  <= 66'(s1_s_q) * 66'(s1_s_q);
      s2_dd_q  <= 36'(s1_md_q) * 36'(s1_md_q);
      s2_s_q   <= s1_s_q;
      s2_mn_q  <= s1_mn_q;
      s2_md_q  <= s1_md_q;
      s2_neg_q <= s1_neg_q;
      s2_st_q  <= s1_st_q;
    end
  end

  // stage 3: divisor products, s^2 * |2C-1| in two halves
  logic [50:0] s3_lo_q, s3_hi_q, s3_sd_q;
  logic [68:0] s3_d3_q;
  logic [63:0] s3_bea_q, s3_aeb_q;
  logic [48:0] s3_nec_q;
  logic [31:0] s3_mn_q;
  logic        s3_neg_q;
  status_e     s3_st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_lo_q  <= 51'(s2_ss_q[32:0]) * 51'(s2_md_q);
      s3_hi_q  <= 51'(s2_ss_q[65:33]) * 51'(s2_md_q);
      s3_d3_q  <= 69'(s2_dd_q) * 69'(s2_s_q);
      s3_sd_q  <= s2_sd_q;
      s3_bea_q <= s2_bea_q;
      s3_aeb_q <= s2_aeb_q;
      s3_nec_q <= s2_nec_q;
      s3_mn_q  <= s2_mn_q;
      s3_neg_q <= s2_neg_q;
      s3_st_q  <= s2_st_q;
    end
  end

  // stage 4: combine halves
  logic [DW-1:0] s4_d12_q, s4_d3_q, s4_sd_q;
  logic [63:0]   s4_bea_q, s4_aeb_q;
  logic [48:0]   s4_nec_q;
  logic [31:0]   s4_mn_q;
  logic          s4_neg_q;
  status_e       s4_st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_d12_q <= DW'(s3_lo_q) + (DW'(s3_hi_q) << 33);
      s4_d3_q  <= DW'(s3_d3_q);
      s4_sd_q  <= DW'(s3_sd_q);
      s4_bea_q <= s3_bea_q;
      s4_aeb_q <= s3_aeb_q;
      s4_nec_q <= s3_nec_q;
      s4_mn_q  <= s3_mn_q;
      s4_neg_q <= s3_neg_q;
      s4_st_q  <= s3_st_q;
    end
  end

  // stage 5: divider setup, overflow when the quotient needs more than QW bits
  logic [NW-1:0] num   [LANES];
  logic [DW-1:0] den   [LANES];
  logic [NW-1:0] num_hi[LANES];
  div_t          dv    [LANES][QW+1];
  logic [LANES-1:0] ovf_d;
  logic [LANES-1:0] ovf_q [QW+1];
  logic          neg_q [QW+1];
  status_e       dst_q [QW+1];

  always_comb begin
    num[0] = NW'(s4_mn_q) << EFF_SH;
    num[1] = NW'(s4_bea_q) << ERR_SH;
    num[2] = NW'(s4_aeb_q) << ERR_SH;
    num[3] = NW'(s4_nec_q) << ERR_SH;
    den[0] = s4_sd_q;
    den[1] = s4_d12_q;
    den[2] = s4_d12_q;
    den[3] = s4_d3_q;
    for (int l = 0; l < LANES; l++) begin
      num_hi[l] = num[l] >> QW;
      ovf_d[l]  = num_hi[l] >= NW'(den[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        dv[l][0].rem    <= DW'(num_hi[l]);
        dv[l][0].den    <= den[l];
        dv[l][0].quo    <= '0;
        dv[l][0].num_lo <= num[l][QW-1:0];
      end
      ovf_q[0] <= ovf_d;
      neg_q[0] <= s4_neg_q;
      dst_q[0] <= s4_st_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      pewe_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (dv[l][k]),
        .d_o   (dv[l][k+1])
      );
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
        dst_q[k+1] <= dst_q[k];
      end
    end
  end

  // stage P1: efficiency rounding and clamp, squares of the error terms
  logic [32:0]        mag;
  logic signed [35:0] ev_abs, ev;
  logic [23:0]        p1_eff_d;
  logic               p1_sat_d;
  logic [23:0]        p1_eff_q;
  logic               p1_sat_q, p1_ovt_q;
  logic [63:0]        p1_sq_q [3];
  status_e            p1_st_q;

  always_comb begin
    mag    = 33'(dv[0][QW].quo)
           + 33'({dv[0][QW].rem, 1'b0} >= {1'b0, dv[0][QW].den});
    ev_abs = $signed({3'b000, mag});
    ev     = (neg_q[QW] ? -ev_abs : ev_abs) + EFF_HALF;
    if (ovf_q[QW][0]) begin
      p1_sat_d = 1'b1;
      p1_eff_d = neg_q[QW] ? EFF_MIN[23:0] : EFF_MAX[23:0];
    end else if (ev > EFF_MAX) begin
      p1_sat_d = 1'b1;
      p1_eff_d = EFF_MAX[23:0];
    end else if (ev < EFF_MIN) begin
      p1_sat_d = 1'b1;
      p1_eff_d = EFF_MIN[23:0];
    end else begin
      p1_sat_d = 1'b0;
      p1_eff_d = ev[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_eff_q <= p1_eff_d;
      p1_sat_q <= p1_sat_d;
      p1_ovt_q <= |ovf_q[QW][LANES-1:1];
      p1_st_q  <= dst_q[QW];
      for (int t = 0; t < 3; t++) begin
        p1_sq_q[t] <= 64'(dv[t+1][QW].quo) * 64'(dv[t+1][QW].quo);
      end
    end
  end

  // stage P2: sum of squares into the root row
  logic [RDW+1:0] sum_sq;
  sqrt_t          sq    [RTW+1];
  logic [23:0]    reff_q[RTW+1];
  logic           rsat_q[RTW+1];
  logic           rovr_q[RTW+1];
  status_e        rst_q [RTW+1];

  assign sum_sq = (RDW+2)'(p1_sq_q[0]) + (RDW+2)'(p1_sq_q[1]) + (RDW+2)'(p1_sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].rad  <= sum_sq[RDW-1:0];
      reff_q[0]  <= p1_eff_q;
      rsat_q[0]  <= p1_sat_q;
      rovr_q[0]  <= p1_ovt_q || (sum_sq[RDW+1:RDW] != 2'b00);
      rst_q[0]   <= p1_st_q;
    end
  end

  for (genvar k = 0; k < RTW; k++) begin : g_root
    pewe_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq[k]),
      .d_o   (sq[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        reff_q[k+1] <= reff_q[k];
        rsat_q[k+1] <= rsat_q[k];
        rovr_q[k+1] <= rovr_q[k];
        rst_q[k+1]  <= rst_q[k];
      end
    end
  end

  // result stage
  res_t res_d, res_q, out_res;

  always_comb begin
    if (rst_q[RTW] != ST_OK) begin
      res_d.eff = '0;
      res_d.err = '0;
      res_d.st  = rst_q[RTW];
    end else begin
      res_d.eff = reff_q[RTW];
      res_d.err = rovr_q[RTW] ? '1 : sq[RTW].root;
      res_d.st  = (rsat_q[RTW] || rovr_q[RTW]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  pewe_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && vld_q[NSTG-1]),
    .data_i  (res_q),
    .full_o  (fifo_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.st, out_res.err, out_res.eff};

  // checks
  a_ready_only_when_backed_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && fifo_full)
    else $error("input stalled with room at the output");

  a_zero_sum_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_res.st == ST_SUM_ZERO || out_res.st == ST_HALF)
      |-> out_res.eff == '0 && out_res.err == '0)
    else $error("flagged item carries nonzero fields");

  a_sat_is_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.st == ST_SAT
      |-> out_res.err == '1 || out_res.eff == EFF_MAX[23:0] || out_res.eff == EFF_MIN[23:0])
    else $error("saturated status without a clamped field");

  a_first_stage_tracks_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

endmodule

// File: verif/tb_top.sv
// Self-checking bench for polarizer_efficiency_with_error_core.
// Predicts efficiency, propagated error and status per bin; needs pewe_pkg.
`timescale 1ns / 1ps

module tb_top;
  import pewe_pkg::*;

  typedef struct packed {
    logic [16:0] ec;
    logic [16:0] c;
    logic [31:0] eb;
    logic [31:0] ea;
    logic [31:0] b;
    logic [31:0] a;
  } bin_t;

  localparam int LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;

  bin_t pending_bins[$];
  res_t expected_res[$];
  int   send_idle = 0;
  int   recv_idle = 0;
  int   errors = 0;
  int   cycles = 0;

  polarizer_efficiency_with_error_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // floor(num / den), returns 1 when the quotient fits 32 bits
  function automatic bit term_fits(logic [127:0] num, logic [127:0] den,
                                   output logic [63:0] t);
    logic [127:0] q;
    q = num / den;
    t = q[63:0];
    return q[127:32] == 0;
  endfunction

  // callers keep x below 2^64, so the root fits 32 bits
  function automatic logic [31:0] isqrt(logic [127:0] x);
    logic [127:0] r, bitv;
    r = 0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic res_t predict_bin(bin_t x);
    res_t r;
    logic [127:0] s, mag_n, mag_d, num, den, q, rm, d12, d3, sum;
    logic [63:0]  t1, t2, t3;
    logic signed [63:0] eff;
    bit neg_n, neg_d, sat, ok;
    s = x.a + x.b;
    neg_n = x.b > x.a;
    mag_n = neg_n ? x.b - x.a : x.a - x.b;
    neg_d = 2 * x.c < CELL_ONE;
    mag_d = neg_d ? CELL_ONE - 2 * x.c : 2 * x.c - CELL_ONE;
    r.eff = '0;
    r.err = '0;
    r.st = ST_OK;
    sat = 1'b0;
    if (s == 0) begin
      r.st = ST_SUM_ZERO;
    end else if (mag_d == 0) begin
      r.st = ST_HALF;
    end else begin
      num = mag_n << EFF_SH;
      den = s * mag_d;
      q = num / den;
      rm = num % den;
      if (rm * 2 >= den) q++;
      eff = (neg_n != neg_d) ? -$signed(q[63:0]) : $signed(q[63:0]);
      eff += 64'sd1 <<< (FRAC_BITS - 1);
      if (eff > 64'sd8388607) begin eff = 64'sd8388607; sat = 1'b1; end
      if (eff < -64'sd8388608) begin eff = -64'sd8388608; sat = 1'b1; end
      r.eff = eff[23:0];
      d12 = s * s * mag_d;
      d3 = mag_d * mag_d * s;
      ok = term_fits((128'(x.b) * x.ea) << ERR_SH, d12, t1);
      if (ok) ok = term_fits((128'(x.a) * x.eb) << ERR_SH, d12, t2);
      if (ok) ok = term_fits((mag_n * x.ec) << ERR_SH, d3, t3);
      if (ok) begin
        sum = 128'(t1) * t1 + 128'(t2) * t2 + 128'(t3) * t3;
        if (sum[127:64] != 0) ok = 1'b0;
        else r.err = isqrt(sum);
      end
      if (!ok) begin
        r.err = 32'hFFFF_FFFF;
        sat = 1'b1;
      end
      if (sat) r.st = ST_SAT;
    end
    return r;
  endfunction

  // driver: one item per handshake, random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bins.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tdata <= 168'(pending_bins[0]);
          expected_res.push_back(predict_bin(pending_bins.pop_front()));
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[23:0], m_axis_tdata[55:24], m_axis_tdata[57:56]};
      if (expected_res.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors = errors + 1;
      end else begin
        want = expected_res.pop_front();
        if (got.eff !== want.eff) begin
          $error("polarizer_efficiency exp %h got %h", want.eff, got.eff);
          errors = errors + 1;
        end
        if (got.err !== want.err) begin
          $error("efficiency_error exp %h got %h", want.err, got.err);
          errors = errors + 1;
        end
        if (got.st !== want.st) begin
          $error("status exp %0d got %0d", want.st, got.st);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(255);
      1: return $urandom_range(32'h000F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic bin_t rand_bin();
    bin_t x;
    x.a = rand_word();
    x.b = ($urandom_range(9) == 0) ? x.a : rand_word();
    if ($urandom_range(19) == 0) begin x.a = 0; x.b = 0; end
    x.ea = rand_word();
    x.eb = rand_word();
    case ($urandom_range(9))
      0: x.c = 17'd32768;
      1: x.c = 17'($urandom_range(17'h1FFFF));
      default: x.c = 17'($urandom_range(65536));
    endcase
    x.ec = ($urandom_range(4) == 0) ? 17'($urandom_range(17'h1FFFF))
                                    : 17'($urandom_range(65536));
    return x;
  endfunction

  task automatic add_bin(logic [31:0] a, b, ea, eb, logic [16:0] c, ec);
    bin_t x;
    x.a = a; x.b = b; x.ea = ea; x.eb = eb; x.c = c; x.ec = ec;
    pending_bins.push_back(x);
  endtask

  task automatic run_phase(int sidle, int ridle, int count);
    send_idle = sidle;
    recv_idle = ridle;
    repeat (count) pending_bins.push_back(rand_bin());
    wait (pending_bins.size() == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: sum zero, half cell, zero sum with half cell, extremes
    add_bin(0, 0, 5, 5, 17'd50000, 17'd10);
    add_bin(32'h10000, 32'h8000, 100, 100, 17'd32768, 17'd10);
    add_bin(0, 0, 1, 1, 17'd32768, 17'd1);
    add_bin(32'h10000, 0, 0, 0, 17'd65536, 17'd0);
    add_bin(0, 32'h10000, 0, 0, 17'd65536, 17'd0);
    add_bin(32'h10000, 32'h10000, 655, 655, 17'd62000, 17'd600);
    add_bin('1, '1, '1, '1, 17'h1FFFF, 17'h1FFFF);
    add_bin('1, 0, '1, '1, 17'd0, 17'd65536);
    add_bin(1, 0, '1, 0, 17'd32769, 17'd65536);
    add_bin(32'h20000, 32'h10000, 200, 300, 17'd32769, 17'd0);
    add_bin(32'h20000, 32'h10000, 200, 300, 17'd32767, 17'd5);
    add_bin(32'h5000, 32'h9000, 1, 1, 17'd0, 17'd65536);
    add_bin(1, 1, 0, 0, 17'd65536, 17'd0);
    add_bin(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
            17'h15555, 17'h0AAAA);
    add_bin(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
            17'h0AAAA, 17'h15555);
    add_bin(32'h1234_5678, 32'h0765_4321, 32'h100, 32'h200, 17'd60000, 17'd100);
    run_phase(0, 0, 0);
    run_phase(16, 70, 500);
    run_phase(70, 16, 500);
    run_phase(0, 0, 500);
    wait (expected_res.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
